### rtl/fmwa_pkg.sv
// Shared types and constants for the force magnitude window average block.
// Used by fmwa_ctrl, fmwa_dp and force_magnitude_window_average; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmwa_pkg;

  // Width of the magnitude, average and force limit values.
  localparam int MAG_W = 24;
  localparam logic [MAG_W-1:0] MAG_MAX = 24'hFF_FFFF;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_LIMIT   = 2'd1;
  localparam logic [MAG_W-1:0] LIMIT_RESET = 24'd65536;

  // Load shade runs from SHADE_FLOOR up to SHADE_FLOOR + SHADE_SPAN.
  localparam int SHADE_W = 8;
  localparam logic [SHADE_W-1:0] SHADE_FLOOR = 8'd51;
  localparam logic [SHADE_W-1:0] SHADE_SPAN  = 8'd204;
  localparam int NUM_W = MAG_W + SHADE_W;

  // One squaring step per component plus one to flush the product register.
  localparam int SQ_STEPS = 4;

  typedef struct packed {
    logic load;
    logic sq_step;
    logic root_init;
    logic root_step;
    logic ring_rd;
    logic win_upd;
    logic div_init;
    logic div_step;
    logic avg_load;
    logic shd_init;
    logic shd_step;
    logic out_load;
  } fmwa_cmd_t;

  typedef struct packed {
    logic enable;
    logic out_busy;
  } fmwa_stat_t;

endpackage

`default_nettype wire

### rtl/fmwa_ctrl.sv
// Sequencing state machine for the force magnitude window average block.
// Drives fmwa_dp through fmwa_pkg::fmwa_cmd_t and reads its fmwa_pkg::fmwa_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module fmwa_ctrl #(
  parameter int COMPONENT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  busy,
  input  fmwa_pkg::fmwa_stat_t  stat,
  output fmwa_pkg::fmwa_cmd_t   cmd
);

  localparam int MAX_STEPS = (COMPONENT_WIDTH > fmwa_pkg::MAG_W) ?
                             COMPONENT_WIDTH : fmwa_pkg::MAG_W;
  localparam int STEP_W = $clog2(MAX_STEPS);

  localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(fmwa_pkg::SQ_STEPS - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(COMPONENT_WIDTH - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(fmwa_pkg::MAG_W - 1);
  localparam logic [STEP_W-1:0] SHD_LAST  = STEP_W'(fmwa_pkg::SHADE_W - 1);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SQUARE    = 4'd1;
  localparam logic [3:0] ST_ROOT_INIT = 4'd2;
  localparam logic [3:0] ST_ROOT      = 4'd3;
  localparam logic [3:0] ST_RING_RD   = 4'd4;
  localparam logic [3:0] ST_UPDATE    = 4'd5;
  localparam logic [3:0] ST_DIV_INIT  = 4'd6;
  localparam logic [3:0] ST_DIV       = 4'd7;
  localparam logic [3:0] ST_AVG       = 4'd8;
  localparam logic [3:0] ST_SHD_INIT  = 4'd9;
  localparam logic [3:0] ST_SHADE     = 4'd10;
  localparam logic [3:0] ST_DONE      = 4'd11;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SQUARE;
          cnt_next   = SQ_LAST;
        end
      end
      ST_SQUARE: begin
        cmd.sq_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_ROOT_INIT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        state_next    = ST_ROOT;
        cnt_next      = ROOT_LAST;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == '0) begin
          // A disabled sensor leaves the window alone and goes straight on to the shade.
          state_next = stat.enable ? ST_RING_RD : ST_SHD_INIT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_RING_RD: begin
        cmd.ring_rd = 1'b1;
        state_next  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.win_upd = 1'b1;
        state_next  = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
        cnt_next     = DIV_LAST;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_AVG;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_AVG: begin
        cmd.avg_load = 1'b1;
        state_next   = ST_SHD_INIT;
      end
      ST_SHD_INIT: begin
        cmd.shd_init = 1'b1;
        state_next   = ST_SHADE;
        cnt_next     = SHD_LAST;
      end
      ST_SHADE: begin
        cmd.shd_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_DONE: begin
        // Hold the finished result until the output register can take it.
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

### rtl/fmwa_dp.sv
// Datapath for the force magnitude window average block: squarer, bit-serial
// square root, magnitude ring, running sum, serial dividers and output register.
// Depends on fmwa_pkg; sequenced by fmwa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fmwa_dp #(
  parameter int WINDOW_DEPTH    = 64,
  parameter int COMPONENT_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fmwa_pkg::fmwa_cmd_t                    cmd,
  output fmwa_pkg::fmwa_stat_t                   stat,
  input  logic signed [COMPONENT_WIDTH-1:0]      force_x,
  input  logic signed [COMPONENT_WIDTH-1:0]      force_y,
  input  logic signed [COMPONENT_WIDTH-1:0]      force_z,
  input  logic                                   cfg_write,
  input  logic [fmwa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fmwa_pkg::MAG_W-1:0]             cfg_data,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic [fmwa_pkg::MAG_W-1:0]             sample_magnitude,
  output logic [fmwa_pkg::MAG_W-1:0]             average_force,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]      samples_held,
  output logic [fmwa_pkg::SHADE_W-1:0]           load_shade
);

  localparam int CW     = COMPONENT_WIDTH;
  localparam int SQ_W   = 2 * CW;
  localparam int REM_W  = CW + 2;
  localparam int RX_W   = (CW > fmwa_pkg::MAG_W) ? CW : fmwa_pkg::MAG_W;
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = fmwa_pkg::MAG_W + SLOT_W;
  localparam int MW     = fmwa_pkg::MAG_W;
  localparam int SW     = fmwa_pkg::SHADE_W;

  // Configuration registers.
  logic          sensor_enable;
  logic [MW-1:0] force_limit;

  // Component magnitudes and sum of squares.
  logic [CW-1:0]   ux, uy, uz;
  logic [CW-1:0]   abs_x, abs_y, abs_z;
  logic [CW-1:0]   c0, c1, c2;
  logic [SQ_W-1:0] prod;
  logic [SQ_W-1:0] acc;

  // Square root, two radicand bits per step.
  logic [SQ_W-1:0]  rad;
  logic [CW-1:0]    root;
  logic [REM_W-1:0] rrem;
  logic [REM_W+1:0] rtrial;
  logic [REM_W+1:0] rtest;
  logic             rge;
  logic [RX_W-1:0]  root_ext;
  logic [MW-1:0]    mag;

  // Window state.
  logic [MW-1:0]    ring [WINDOW_DEPTH];
  logic [MW-1:0]    old_mag;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [MW-1:0]    last_average;
  logic             full;

  // Mean divider: the quotient is known to fit in MW bits.
  logic [CNT_W-1:0] drem;
  logic [MW-1:0]    dq;
  logic [CNT_W:0]   dtrial;
  logic             dge;

  // Shade divider: the quotient is known to stay below 2**SW.
  logic [fmwa_pkg::NUM_W-1:0] num;
  logic [MW-1:0]    srem;
  logic [SW-1:0]    sq;
  logic [MW:0]      strial;
  logic             sge;
  logic             shd_sat;
  logic [SW-1:0]    shade;

  assign ux = force_x;
  assign uy = force_y;
  assign uz = force_z;
  assign abs_x = ux[CW-1] ? (~ux + CW'(1'b1)) : ux;
  assign abs_y = uy[CW-1] ? (~uy + CW'(1'b1)) : uy;
  assign abs_z = uz[CW-1] ? (~uz + CW'(1'b1)) : uz;

  assign rtrial = {rrem, rad[SQ_W-1 -: 2]};
  assign rtest  = (REM_W + 2)'({root, 2'b01});
  assign rge    = (rtrial >= rtest);

  assign root_ext = RX_W'(root);
  assign mag = (root_ext > RX_W'(fmwa_pkg::MAG_MAX)) ? fmwa_pkg::MAG_MAX : root_ext[MW-1:0];

  assign full = (count == CNT_W'(WINDOW_DEPTH));

  assign dtrial = {drem, dq[MW-1]};
  assign dge    = (dtrial >= {1'b0, count});

  assign num    = fmwa_pkg::NUM_W'(force_limit - last_average) *
                  fmwa_pkg::NUM_W'(fmwa_pkg::SHADE_SPAN);
  assign strial = {srem, sq[SW-1]};
  assign sge    = (strial >= {1'b0, force_limit});
  assign shade  = shd_sat ? fmwa_pkg::SHADE_FLOOR : (fmwa_pkg::SHADE_FLOOR + sq);

  assign stat.enable   = sensor_enable;
  assign stat.out_busy = out_valid && out_stall;

  // Control state, configuration and window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enable <= 1'b0;
      force_limit   <= fmwa_pkg::LIMIT_RESET;
      slot          <= '0;
      count         <= '0;
      sum           <= '0;
      last_average  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fmwa_pkg::REG_SENSOR_ENABLE: sensor_enable <= cfg_data[0];
          fmwa_pkg::REG_FORCE_LIMIT:   force_limit   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.win_upd) begin
        // Once the window is full the oldest magnitude leaves as the new one enters.
        if (full) begin
          sum <= sum - SUM_W'(old_mag) + SUM_W'(mag);
        end else begin
          sum   <= sum + SUM_W'(mag);
          count <= count + 1'b1;
        end
        if (slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
      if (cmd.avg_load) begin
        last_average <= dq;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Magnitude ring with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.win_upd) begin
      ring[slot] <= mag;
    end
    if (cmd.ring_rd) begin
      old_mag <= ring[slot];
    end
  end

  // Arithmetic working registers and the output payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c0   <= abs_x;
      c1   <= abs_y;
      c2   <= abs_z;
      prod <= '0;
      acc  <= '0;
    end
    if (cmd.sq_step) begin
      prod <= c0 * c0;
      acc  <= acc + prod;
      c0   <= c1;
      c1   <= c2;
      c2   <= '0;
    end
    if (cmd.root_init) begin
      rad  <= acc;
      root <= '0;
      rrem <= '0;
    end
    if (cmd.root_step) begin
      rrem <= rge ? REM_W'(rtrial - rtest) : REM_W'(rtrial);
      root <= {root[CW-2:0], rge};
      rad  <= {rad[SQ_W-3:0], 2'b00};
    end
    if (cmd.div_init) begin
      drem <= CNT_W'(sum[SUM_W-1:MW]);
      dq   <= sum[MW-1:0];
    end
    if (cmd.div_step) begin
      drem <= dge ? CNT_W'(dtrial - {1'b0, count}) : dtrial[CNT_W-1:0];
      dq   <= {dq[MW-2:0], dge};
    end
    if (cmd.shd_init) begin
      // At or above the limit (a zero limit included) the shade sits at its floor.
      shd_sat <= (last_average >= force_limit);
      srem    <= num[fmwa_pkg::NUM_W-1:SW];
      sq      <= num[SW-1:0];
    end
    if (cmd.shd_step) begin
      srem <= sge ? MW'(strial - {1'b0, force_limit}) : strial[MW-1:0];
      sq   <= {sq[SW-2:0], sge};
    end
    if (cmd.out_load) begin
      sample_magnitude <= mag;
      average_force    <= last_average;
      samples_held     <= count;
      load_shade       <= shade;
    end
  end

endmodule

`default_nettype wire

### rtl/force_magnitude_window_average.sv
// One item is in work at a time: the block stalls its input from the transfer until
// the result is loaded into the output register. A disabled sensor skips the ring
// read, window update and mean divider. The bit-serial square root and the
// one-bit-per-cycle mean divider set the time that an item takes.
// Reset clears control, counters, running sum and configuration; the magnitude
// ring is not cleared since an entry's value is used only after it has been written.
`timescale 1ns / 1ps
`default_nettype none

module force_magnitude_window_average #(
  parameter int WINDOW_DEPTH    = 64,
  parameter int COMPONENT_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [fmwa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fmwa_pkg::MAG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0]      force_x,
  input  logic signed [COMPONENT_WIDTH-1:0]      force_y,
  input  logic signed [COMPONENT_WIDTH-1:0]      force_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [fmwa_pkg::MAG_W-1:0]             sample_magnitude,
  output logic [fmwa_pkg::MAG_W-1:0]             average_force,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]      samples_held,
  output logic [fmwa_pkg::SHADE_W-1:0]           load_shade
);

  fmwa_pkg::fmwa_cmd_t  cmd;
  fmwa_pkg::fmwa_stat_t stat;
  logic                 busy;

  fmwa_ctrl #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .busy     (busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  fmwa_dp #(
    .WINDOW_DEPTH    (WINDOW_DEPTH),
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .force_x          (force_x),
    .force_y          (force_y),
    .force_z          (force_z),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .sample_magnitude (sample_magnitude),
    .average_force    (average_force),
    .samples_held     (samples_held),
    .load_shade       (load_shade)
  );

  assign in_stall = busy;

  // The sequencer never issues two datapath operations in one cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command active");

  // An input transfer starts work, so the block stalls in the following cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after input transfer");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy)
    else $error("result loaded over a stalled result");

  // A result appears only after the sequencer loads one.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

endmodule

`default_nettype wire
